@@ rtl/core/rcs_pkg.sv @@
// ---------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants for the reliable channel sequencer.
// ---------------------------------------------------------------------------
package rcs_pkg;

    localparam int SEQ_BITS   = 31;
    localparam int WORD_BITS  = 32;
    localparam int TAG_BITS   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int HDR_BYTES  = 8;
    localparam int TAG_BYTES  = 2;
    localparam int MAX_PKT_RESET = 1400;

    typedef logic [SEQ_BITS-1:0]   t_seq;
    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [TAG_BITS-1:0]   t_tag;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_IS_CLIENT   = 2'd0;
    localparam t_cfg_idx CFG_PORT_TAG    = 2'd1;
    localparam t_cfg_idx CFG_MAX_PKT     = 2'd2;

    localparam logic ACT_TRANSMIT = 1'b0;
    localparam logic ACT_RECEIVE  = 1'b1;

endpackage

@@ rtl/core/rcs_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// rcs_cfg_regs
// Configuration registers: client flag, port tag and packet size limit.
// ---------------------------------------------------------------------------
module rcs_cfg_regs #(
    parameter int LENGTH_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  rcs_pkg::t_cfg_idx        i_cfg_index,
    input  rcs_pkg::t_cfg_data       i_cfg_wdata,
    output logic                     o_is_client,
    output rcs_pkg::t_tag            o_port_tag,
    output logic [LENGTH_BITS-1:0]   o_max_packet_bytes
);
    import rcs_pkg::*;

    logic                   r_is_client;
    t_tag                   r_port_tag;
    logic [LENGTH_BITS-1:0] r_max_packet_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_client        <= 1'b0;
            r_port_tag         <= '0;
            r_max_packet_bytes <= LENGTH_BITS'(MAX_PKT_RESET);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IS_CLIENT: r_is_client        <= i_cfg_wdata[0];
                CFG_PORT_TAG:  r_port_tag         <= i_cfg_wdata[TAG_BITS-1:0];
                CFG_MAX_PKT:   r_max_packet_bytes <= i_cfg_wdata[LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_is_client        = r_is_client;
    assign o_port_tag         = r_port_tag;
    assign o_max_packet_bytes = r_max_packet_bytes;

endmodule

@@ rtl/core/rcs_seq_engine.sv @@
// ---------------------------------------------------------------------------
// rcs_seq_engine
// Channel state and the single-pass header logic for one transmit or
// receive event. State advances when the top level moves the word on.
// ---------------------------------------------------------------------------
module rcs_seq_engine #(
    parameter int LENGTH_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    input  logic                   i_is_client,
    input  rcs_pkg::t_tag          i_port_tag,
    input  logic [LENGTH_BITS-1:0] i_max_packet_bytes,
    input  logic                   i_action,
    input  rcs_pkg::t_word         i_rx_word_a,
    input  rcs_pkg::t_word         i_rx_word_b,
    input  logic [LENGTH_BITS-1:0] i_pending_length,
    input  logic                   i_pending_overflowed,
    input  logic [LENGTH_BITS-1:0] i_unreliable_length,
    output logic                   o_accepted,
    output logic                   o_ovf_latched,
    output rcs_pkg::t_word         o_tx_word_a,
    output rcs_pkg::t_word         o_tx_word_b,
    output logic                   o_tag_present,
    output rcs_pkg::t_tag          o_tag_value,
    output logic                   o_rel_attached,
    output logic [LENGTH_BITS-1:0] o_reliable_bytes,
    output logic                   o_unreliable_included,
    output logic                   o_message_taken,
    output rcs_pkg::t_seq          o_dropped_count,
    output logic [LENGTH_BITS-1:0] o_packet_length
);
    import rcs_pkg::*;

    localparam int SZ_W = LENGTH_BITS + 2;

    t_seq                   r_out_seq,      n_out_seq;
    t_seq                   r_in_seq,       n_in_seq;
    t_seq                   r_in_acked,     n_in_acked;
    logic                   r_in_rel_acked, n_in_rel_acked;
    logic                   r_in_rel_bit,   n_in_rel_bit;
    logic                   r_out_rel_bit,  n_out_rel_bit;
    t_seq                   r_last_rel_sent, n_last_rel_sent;
    logic [LENGTH_BITS-1:0] r_stored_rel_len, n_stored_rel_len;
    logic                   r_fatal_flag,   n_fatal_flag;

    logic                   w_resend;
    logic                   w_take;
    logic                   w_send;
    logic [LENGTH_BITS-1:0] w_rel_len;
    t_seq                   w_out_seq_inc;
    logic [SZ_W-1:0]        w_base;
    logic [SZ_W-1:0]        w_size_rel;
    logic [SZ_W-1:0]        w_max;
    logic [SZ_W-1:0]        w_room;
    logic [SZ_W-1:0]        w_ulen;
    logic                   w_incl;
    logic [SZ_W-1:0]        w_size_tot;
    logic [LENGTH_BITS-1:0] w_size_sat;
    t_seq                   w_rx_seq;
    t_seq                   w_rx_ack;
    logic                   w_stale;

    assign w_resend = (r_in_acked > r_last_rel_sent) && (r_in_rel_acked != r_out_rel_bit);
    assign w_take   = (r_stored_rel_len == '0) && (i_pending_length != '0);
    assign w_send   = w_resend || w_take;
    assign w_rel_len = w_take ? i_pending_length : r_stored_rel_len;
    assign w_out_seq_inc = r_out_seq + t_seq'(1);

    assign w_base     = i_is_client ? SZ_W'(HDR_BYTES + TAG_BYTES) : SZ_W'(HDR_BYTES);
    assign w_size_rel = w_base + (w_send ? {2'b00, w_rel_len} : '0);
    assign w_max      = {2'b00, i_max_packet_bytes};
    assign w_room     = (w_max > w_size_rel) ? (w_max - w_size_rel) : '0;
    assign w_ulen     = {2'b00, i_unreliable_length};
    assign w_incl     = (w_room >= w_ulen);
    assign w_size_tot = w_size_rel + (w_incl ? w_ulen : '0);
    assign w_size_sat = (|w_size_tot[SZ_W-1:LENGTH_BITS]) ? '1 : w_size_tot[LENGTH_BITS-1:0];

    assign w_rx_seq = i_rx_word_a[SEQ_BITS-1:0];
    assign w_rx_ack = i_rx_word_b[SEQ_BITS-1:0];
    assign w_stale  = (w_rx_seq <= r_in_seq);

    always_comb begin
        n_out_seq        = r_out_seq;
        n_in_seq         = r_in_seq;
        n_in_acked       = r_in_acked;
        n_in_rel_acked   = r_in_rel_acked;
        n_in_rel_bit     = r_in_rel_bit;
        n_out_rel_bit    = r_out_rel_bit;
        n_last_rel_sent  = r_last_rel_sent;
        n_stored_rel_len = r_stored_rel_len;
        n_fatal_flag     = r_fatal_flag;

        o_accepted            = 1'b0;
        o_ovf_latched         = r_fatal_flag;
        o_tx_word_a           = '0;
        o_tx_word_b           = '0;
        o_tag_present         = 1'b0;
        o_tag_value           = '0;
        o_rel_attached        = 1'b0;
        o_reliable_bytes      = '0;
        o_unreliable_included = 1'b0;
        o_message_taken       = 1'b0;
        o_dropped_count       = '0;
        o_packet_length       = '0;

        if (i_action == ACT_RECEIVE) begin
            if (!w_stale) begin
                o_accepted      = 1'b1;
                o_dropped_count = w_rx_seq - r_in_seq - t_seq'(1);
                if (i_rx_word_b[SEQ_BITS] == r_out_rel_bit) begin
                    n_stored_rel_len = '0;
                end
                n_in_seq       = w_rx_seq;
                n_in_acked     = w_rx_ack;
                n_in_rel_acked = i_rx_word_b[SEQ_BITS];
                n_in_rel_bit   = r_in_rel_bit ^ i_rx_word_a[SEQ_BITS];
            end
        end else if (i_pending_overflowed) begin
            n_fatal_flag  = 1'b1;
            o_ovf_latched = 1'b1;
        end else begin
            n_stored_rel_len = w_rel_len;
            n_out_rel_bit    = r_out_rel_bit ^ w_take;
            n_out_seq        = w_out_seq_inc;
            if (w_send) begin
                n_last_rel_sent = w_out_seq_inc;
            end
            o_accepted            = 1'b1;
            o_tx_word_a           = {w_send, r_out_seq};
            o_tx_word_b           = {r_in_rel_bit, r_in_seq};
            o_tag_present         = i_is_client;
            o_tag_value           = i_is_client ? i_port_tag : '0;
            o_rel_attached        = w_send;
            o_reliable_bytes      = w_send ? w_rel_len : '0;
            o_unreliable_included = w_incl;
            o_message_taken       = w_take;
            o_packet_length       = w_size_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_seq        <= t_seq'(1);
            r_in_seq         <= '0;
            r_in_acked       <= '0;
            r_in_rel_acked   <= 1'b0;
            r_in_rel_bit     <= 1'b0;
            r_out_rel_bit    <= 1'b0;
            r_last_rel_sent  <= '0;
            r_stored_rel_len <= '0;
            r_fatal_flag     <= 1'b0;
        end else if (i_go) begin
            r_out_seq        <= n_out_seq;
            r_in_seq         <= n_in_seq;
            r_in_acked       <= n_in_acked;
            r_in_rel_acked   <= n_in_rel_acked;
            r_in_rel_bit     <= n_in_rel_bit;
            r_out_rel_bit    <= n_out_rel_bit;
            r_last_rel_sent  <= n_last_rel_sent;
            r_stored_rel_len <= n_stored_rel_len;
            r_fatal_flag     <= n_fatal_flag;
        end
    end

`ifndef SYNTHESIS
    // once set, the fatal flag stays
    a_fatal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fatal_flag |=> r_fatal_flag)
        else $error("fatal flag cleared");

    // a newly taken message always lands in an empty store
    a_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && w_take && i_action == ACT_TRANSMIT && !i_pending_overflowed
        |=> r_stored_rel_len != '0)
        else $error("taken message not stored");

    // an accepted receive moves the incoming sequence strictly forward
    a_in_seq_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && i_action == ACT_RECEIVE && !w_stale |=> r_in_seq > $past(r_in_seq))
        else $error("incoming sequence did not advance");
`endif

endmodule

@@ rtl/core/reliable_channel_sequencer_top.sv @@
// ---------------------------------------------------------------------------
// reliable_channel_sequencer_top
// Header sequencing for an alternating-bit reliable datagram channel.
//
// One transmit or receive event is taken per clock while o_stall is low and
// yields one result word. The event is captured in an input register,
// passes through the sequence compare and length adds of the engine, and
// lands in the result register while the channel state updates. The result
// register lets the next event enter while a result still waits on i_stall.
// ---------------------------------------------------------------------------
module reliable_channel_sequencer_top #(
    parameter int LENGTH_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  rcs_pkg::t_cfg_idx         i_cfg_index,
    input  rcs_pkg::t_cfg_data        i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_action,
    input  rcs_pkg::t_word            i_rx_word_a,
    input  rcs_pkg::t_word            i_rx_word_b,
    input  logic [LENGTH_BITS-1:0]    i_pending_length,
    input  logic                      i_pending_overflowed,
    input  logic [LENGTH_BITS-1:0]    i_unreliable_length,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_accepted,
    output logic                      o_ovf_latched,
    output rcs_pkg::t_word            o_tx_word_a,
    output rcs_pkg::t_word            o_tx_word_b,
    output logic                      o_tag_present,
    output rcs_pkg::t_tag             o_tag_value,
    output logic                      o_rel_attached,
    output logic [LENGTH_BITS-1:0]    o_reliable_bytes,
    output logic                      o_unreliable_included,
    output logic                      o_message_taken,
    output rcs_pkg::t_seq             o_dropped_count,
    output logic [LENGTH_BITS-1:0]    o_packet_length
);
    import rcs_pkg::*;

    logic                   w_is_client;
    t_tag                   w_port_tag;
    logic [LENGTH_BITS-1:0] w_max_packet_bytes;

    logic                   r_in_valid;
    logic                   r_in_action;
    t_word                  r_in_rx_word_a;
    t_word                  r_in_rx_word_b;
    logic [LENGTH_BITS-1:0] r_in_pending_length;
    logic                   r_in_pending_overflowed;
    logic [LENGTH_BITS-1:0] r_in_unreliable_length;

    logic                   w_out_free;
    logic                   w_move;
    logic                   w_load;

    logic                   w_accepted;
    logic                   w_ovf_latched;
    t_word                  w_tx_word_a;
    t_word                  w_tx_word_b;
    logic                   w_tag_present;
    t_tag                   w_tag_value;
    logic                   w_rel_attached;
    logic [LENGTH_BITS-1:0] w_reliable_bytes;
    logic                   w_unreliable_included;
    logic                   w_message_taken;
    t_seq                   w_dropped_count;
    logic [LENGTH_BITS-1:0] w_packet_length;

    logic                   r_out_valid;
    logic                   r_accepted;
    logic                   r_ovf_latched;
    t_word                  r_tx_word_a;
    t_word                  r_tx_word_b;
    logic                   r_tag_present;
    t_tag                   r_tag_value;
    logic                   r_rel_attached;
    logic [LENGTH_BITS-1:0] r_reliable_bytes;
    logic                   r_unreliable_included;
    logic                   r_message_taken;
    t_seq                   r_dropped_count;
    logic [LENGTH_BITS-1:0] r_packet_length;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_move     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_load     = i_valid && !o_stall;

    rcs_cfg_regs #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_is_client        (w_is_client),
        .o_port_tag         (w_port_tag),
        .o_max_packet_bytes (w_max_packet_bytes)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_load) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_action             <= i_action;
            r_in_rx_word_a          <= i_rx_word_a;
            r_in_rx_word_b          <= i_rx_word_b;
            r_in_pending_length     <= i_pending_length;
            r_in_pending_overflowed <= i_pending_overflowed;
            r_in_unreliable_length  <= i_unreliable_length;
        end
    end

    rcs_seq_engine #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_engine (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_go                  (w_move),
        .i_is_client           (w_is_client),
        .i_port_tag            (w_port_tag),
        .i_max_packet_bytes    (w_max_packet_bytes),
        .i_action              (r_in_action),
        .i_rx_word_a           (r_in_rx_word_a),
        .i_rx_word_b           (r_in_rx_word_b),
        .i_pending_length      (r_in_pending_length),
        .i_pending_overflowed  (r_in_pending_overflowed),
        .i_unreliable_length   (r_in_unreliable_length),
        .o_accepted            (w_accepted),
        .o_ovf_latched         (w_ovf_latched),
        .o_tx_word_a           (w_tx_word_a),
        .o_tx_word_b           (w_tx_word_b),
        .o_tag_present         (w_tag_present),
        .o_tag_value           (w_tag_value),
        .o_rel_attached        (w_rel_attached),
        .o_reliable_bytes      (w_reliable_bytes),
        .o_unreliable_included (w_unreliable_included),
        .o_message_taken       (w_message_taken),
        .o_dropped_count       (w_dropped_count),
        .o_packet_length       (w_packet_length)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_accepted            <= w_accepted;
            r_ovf_latched         <= w_ovf_latched;
            r_tx_word_a           <= w_tx_word_a;
            r_tx_word_b           <= w_tx_word_b;
            r_tag_present         <= w_tag_present;
            r_tag_value           <= w_tag_value;
            r_rel_attached        <= w_rel_attached;
            r_reliable_bytes      <= w_reliable_bytes;
            r_unreliable_included <= w_unreliable_included;
            r_message_taken       <= w_message_taken;
            r_dropped_count       <= w_dropped_count;
            r_packet_length       <= w_packet_length;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_accepted            = r_accepted;
    assign o_ovf_latched         = r_ovf_latched;
    assign o_tx_word_a           = r_tx_word_a;
    assign o_tx_word_b           = r_tx_word_b;
    assign o_tag_present         = r_tag_present;
    assign o_tag_value           = r_tag_value;
    assign o_rel_attached        = r_rel_attached;
    assign o_reliable_bytes      = r_reliable_bytes;
    assign o_unreliable_included = r_unreliable_included;
    assign o_message_taken       = r_message_taken;
    assign o_dropped_count       = r_dropped_count;
    assign o_packet_length       = r_packet_length;

`ifndef SYNTHESIS
    // a held input word is not lost while the result side is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_move |=> r_in_valid)
        else $error("input word dropped while stalled");

    // a taken message is always sent in the same packet
    a_taken_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_taken |-> o_rel_attached && o_accepted)
        else $error("message taken but not sent");

    // skipped sequences only reported on an accepted receive
    a_drop_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dropped_count != '0 |-> o_accepted && !o_tag_present)
        else $error("dropped count on a rejected or transmit word");
`endif

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for reliable_channel_sequencer_top
// A short table of transmit, receive and register rows is walked first, save
// its closing rows, which run last. Some rows carry a hand-typed result; all
// other rows are checked against a cycle-free model of the channel state.
// Random traffic runs between, in phases with different register settings,
// sender gaps and receiver stalls, one long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcs_pkg::*;

    localparam int LEN_W       = 12;
    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PLAN_ROWS   = 28;
    localparam int OPEN_ROWS   = 23;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic             act;
        t_word            a;
        t_word            b;
        logic [LEN_W-1:0] pend;
        logic             ovf;
        logic [LEN_W-1:0] ulen;
    } t_pkt_event;

    typedef struct packed {
        logic             acc;
        logic             fatal;
        t_word            word_a;
        t_word            word_b;
        logic             tag_on;
        t_tag             tag;
        logic             rel_on;
        logic [LEN_W-1:0] rel_len;
        logic             unrel_on;
        logic             taken;
        t_seq             dropped;
        logic [LEN_W-1:0] pkt_len;
    } t_header_res;

    typedef struct packed {
        logic        is_cfg;
        t_cfg_idx    reg_idx;
        t_cfg_data   reg_val;
        t_pkt_event  ev;
        logic        typed;
        t_header_res want;
    } t_plan_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    t_cfg_idx         i_cfg_index = '0;
    t_cfg_data        i_cfg_wdata = '0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic             i_action = ACT_TRANSMIT;
    t_word            i_rx_word_a = '0;
    t_word            i_rx_word_b = '0;
    logic [LEN_W-1:0] i_pending_length = '0;
    logic             i_pending_overflowed = 1'b0;
    logic [LEN_W-1:0] i_unreliable_length = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic             o_accepted;
    logic             o_ovf_latched;
    t_word            o_tx_word_a;
    t_word            o_tx_word_b;
    logic             o_tag_present;
    t_tag             o_tag_value;
    logic             o_rel_attached;
    logic [LEN_W-1:0] o_reliable_bytes;
    logic             o_unreliable_included;
    logic             o_message_taken;
    t_seq             o_dropped_count;
    logic [LEN_W-1:0] o_packet_length;

    reliable_channel_sequencer_top #(.LENGTH_BITS(LEN_W)) dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_action              (i_action),
        .i_rx_word_a           (i_rx_word_a),
        .i_rx_word_b           (i_rx_word_b),
        .i_pending_length      (i_pending_length),
        .i_pending_overflowed  (i_pending_overflowed),
        .i_unreliable_length   (i_unreliable_length),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_accepted            (o_accepted),
        .o_ovf_latched         (o_ovf_latched),
        .o_tx_word_a           (o_tx_word_a),
        .o_tx_word_b           (o_tx_word_b),
        .o_tag_present         (o_tag_present),
        .o_tag_value           (o_tag_value),
        .o_rel_attached        (o_rel_attached),
        .o_reliable_bytes      (o_reliable_bytes),
        .o_unreliable_included (o_unreliable_included),
        .o_message_taken       (o_message_taken),
        .o_dropped_count       (o_dropped_count),
        .o_packet_length       (o_packet_length)
    );

    // channel state mirror
    t_seq             tx_seq = 31'd1;
    t_seq             rx_seq = '0;
    t_seq             rx_ack_seq = '0;
    logic             rx_ack_par = 1'b0;
    logic             rx_par = 1'b0;
    logic             tx_par = 1'b0;
    t_seq             rel_sent_mark = '0;
    logic [LEN_W-1:0] rel_store_len = '0;
    logic             fatal_seen = 1'b0;
    logic             cfg_client = 1'b0;
    t_tag             cfg_tag = '0;
    logic [LEN_W-1:0] cfg_max = LEN_W'(MAX_PKT_RESET);

    t_header_res      due_headers[$];
    t_plan_row        plan [PLAN_ROWS];
    int unsigned      mismatch_count = 0;
    int unsigned      cycle_count = 0;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    int               hold_seq = 0;
    int               hold_seen = 0;
    int               hold_left = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic t_header_res step_channel(t_pkt_event e);
        t_header_res r;
        t_seq        seq;
        int unsigned pkt_bytes;
        int unsigned room;
        r = '0;
        if (e.act == ACT_RECEIVE) begin
            r.fatal = fatal_seen;
            seq = e.a[30:0];
            if (seq > rx_seq) begin
                r.acc     = 1'b1;
                r.dropped = seq - (rx_seq + 1'b1);
                if (e.b[31] == tx_par)
                    rel_store_len = '0;
                rx_seq     = seq;
                rx_ack_seq = e.b[30:0];
                rx_ack_par = e.b[31];
                if (e.a[31])
                    rx_par = ~rx_par;
            end
        end else if (e.ovf) begin
            fatal_seen = 1'b1;
            r.fatal    = 1'b1;
        end else begin
            r.rel_on = (rx_ack_seq > rel_sent_mark) && (rx_ack_par != tx_par);
            if (rel_store_len == 0 && e.pend != 0) begin
                r.rel_on      = 1'b1;
                rel_store_len = e.pend;
                tx_par        = ~tx_par;
                r.taken       = 1'b1;
            end
            r.word_a = {r.rel_on, tx_seq};
            r.word_b = {rx_par, rx_seq};
            tx_seq   = tx_seq + 1'b1;
            pkt_bytes = cfg_client ? HDR_BYTES + TAG_BYTES : HDR_BYTES;
            if (r.rel_on) begin
                pkt_bytes     = pkt_bytes + rel_store_len;
                rel_sent_mark = tx_seq;
            end
            room = (cfg_max > pkt_bytes) ? cfg_max - pkt_bytes : 0;
            r.unrel_on = (room >= e.ulen);
            if (r.unrel_on)
                pkt_bytes = pkt_bytes + e.ulen;
            r.acc     = 1'b1;
            r.fatal   = fatal_seen;
            r.tag_on  = cfg_client;
            r.tag     = cfg_client ? cfg_tag : '0;
            r.rel_len = r.rel_on ? rel_store_len : '0;
            r.pkt_len = (pkt_bytes > 4095) ? '1 : LEN_W'(pkt_bytes);
        end
        return r;
    endfunction

    // mostly in-order traffic that tracks the far end, plus stale noise
    function automatic t_pkt_event make_event();
        t_pkt_event  e;
        int unsigned pick;
        t_seq        seq;
        t_seq        ack;
        e = '0;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            e.act = ACT_TRANSMIT;
            case ($urandom_range(0, 3))
                0, 1: e.pend = '0;
                2: e.pend = LEN_W'($urandom_range(1, 300));
                default: e.pend = LEN_W'($urandom_range(1, 4095));
            endcase
            if ($urandom_range(0, 3) == 0)
                e.ulen = LEN_W'($urandom_range(0, 4095));
            else
                e.ulen = LEN_W'($urandom_range(0, 1400));
        end else if (pick < 85) begin
            e.act = ACT_RECEIVE;
            if ($urandom_range(0, 9) == 0)
                seq = rx_seq + t_seq'($urandom_range(4, 5000));
            else
                seq = rx_seq + t_seq'($urandom_range(1, 3));
            if ($urandom_range(0, 7) == 0)
                ack = t_seq'($urandom);
            else
                ack = tx_seq - t_seq'($urandom_range(1, 3));
            e.a[31]   = 1'($urandom_range(0, 1));
            e.a[30:0] = seq;
            e.b[31]   = ($urandom_range(0, 9) < 6) ? tx_par : ~tx_par;
            e.b[30:0] = ack;
        end else begin
            e.act     = ACT_RECEIVE;
            e.a[31]   = 1'($urandom_range(0, 1));
            e.a[30:0] = t_seq'($urandom_range(0, rx_seq));
            e.b       = $urandom;
        end
        return e;
    endfunction

    function automatic t_plan_row tx_row(logic [LEN_W-1:0] pend, logic ovf,
                                         logic [LEN_W-1:0] ulen);
        t_plan_row p;
        p = '0;
        p.ev.act  = ACT_TRANSMIT;
        p.ev.pend = pend;
        p.ev.ovf  = ovf;
        p.ev.ulen = ulen;
        return p;
    endfunction

    function automatic t_plan_row rx_row(t_word a, t_word b);
        t_plan_row p;
        p = '0;
        p.ev.act = ACT_RECEIVE;
        p.ev.a   = a;
        p.ev.b   = b;
        return p;
    endfunction

    function automatic t_plan_row cfg_row(t_cfg_idx idx, t_cfg_data val);
        t_plan_row p;
        p = '0;
        p.is_cfg  = 1'b1;
        p.reg_idx = idx;
        p.reg_val = val;
        return p;
    endfunction

    function automatic t_plan_row with_want(t_plan_row p, t_header_res w);
        p.typed = 1'b1;
        p.want  = w;
        return p;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("ERROR cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_header_res got;
        t_header_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_accepted, o_ovf_latched, o_tx_word_a, o_tx_word_b, o_tag_present,
                   o_tag_value, o_rel_attached, o_reliable_bytes, o_unreliable_included,
                   o_message_taken, o_dropped_count, o_packet_length};
            if (due_headers.size() == 0) begin
                flag_mismatch("word with none due", 32'(got.word_a), 32'd0);
            end else begin
                want = due_headers.pop_front();
                if (got.acc !== want.acc)
                    flag_mismatch("accepted", 32'(got.acc), 32'(want.acc));
                if (got.fatal !== want.fatal)
                    flag_mismatch("ovf_latched", 32'(got.fatal), 32'(want.fatal));
                if (got.word_a !== want.word_a)
                    flag_mismatch("tx_word_a", got.word_a, want.word_a);
                if (got.word_b !== want.word_b)
                    flag_mismatch("tx_word_b", got.word_b, want.word_b);
                if (got.tag_on !== want.tag_on)
                    flag_mismatch("tag_present", 32'(got.tag_on), 32'(want.tag_on));
                if (got.tag !== want.tag)
                    flag_mismatch("tag_value", 32'(got.tag), 32'(want.tag));
                if (got.rel_on !== want.rel_on)
                    flag_mismatch("rel_attached", 32'(got.rel_on), 32'(want.rel_on));
                if (got.rel_len !== want.rel_len)
                    flag_mismatch("reliable_bytes", 32'(got.rel_len), 32'(want.rel_len));
                if (got.unrel_on !== want.unrel_on)
                    flag_mismatch("unreliable_included", 32'(got.unrel_on),
                                  32'(want.unrel_on));
                if (got.taken !== want.taken)
                    flag_mismatch("message_taken", 32'(got.taken), 32'(want.taken));
                if (got.dropped !== want.dropped)
                    flag_mismatch("dropped_count", 32'(got.dropped), 32'(want.dropped));
                if (got.pkt_len !== want.pkt_len)
                    flag_mismatch("packet_length", 32'(got.pkt_len), 32'(want.pkt_len));
            end
        end
    end

    task automatic send_word(t_pkt_event e);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid              <= 1'b1;
        i_action             <= e.act;
        i_rx_word_a          <= e.a;
        i_rx_word_b          <= e.b;
        i_pending_length     <= e.pend;
        i_pending_overflowed <= e.ovf;
        i_unreliable_length  <= e.ulen;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_random(int count);
        t_pkt_event e;
        repeat (count) begin
            e = make_event();
            due_headers.push_back(step_channel(e));
            send_word(e);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (due_headers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_data val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_IS_CLIENT: cfg_client = val[0];
            CFG_PORT_TAG:  cfg_tag    = val;
            CFG_MAX_PKT:   cfg_max    = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic walk_plan(int first, int last);
        t_header_res res;
        for (int i = first; i < last; i++) begin
            if (plan[i].is_cfg) begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                res = step_channel(plan[i].ev);
                due_headers.push_back(plan[i].typed ? plan[i].want : res);
                send_word(plan[i].ev);
            end
        end
    endtask

    task automatic run_phase(int count, int idle_pct, int stall_rate, logic client,
                             t_tag tag_val, logic [LEN_W-1:0] max_bytes);
        drain();
        write_reg(CFG_IS_CLIENT, t_cfg_data'(client));
        write_reg(CFG_PORT_TAG, tag_val);
        write_reg(CFG_MAX_PKT, t_cfg_data'(max_bytes));
        send_idle_pct = idle_pct;
        stall_pct    <= stall_rate;
        send_random(count);
    endtask

    initial begin
        plan = '{
            with_want(tx_row(12'd0, 1'b0, 12'd0), t_header_res'{1'b1, 1'b0, 32'h1, 32'h0,
                      1'b0, 16'h0, 1'b0, 12'd0, 1'b1, 1'b0, 31'd0, 12'd8}),
            with_want(tx_row(12'd0, 1'b0, 12'd1392), t_header_res'{1'b1, 1'b0, 32'h2, 32'h0,
                      1'b0, 16'h0, 1'b0, 12'd0, 1'b1, 1'b0, 31'd0, 12'd1400}),
            with_want(tx_row(12'd0, 1'b0, 12'd1393), t_header_res'{1'b1, 1'b0, 32'h3, 32'h0,
                      1'b0, 16'h0, 1'b0, 12'd0, 1'b0, 1'b0, 31'd0, 12'd8}),
            with_want(rx_row(32'h0, 32'hFFFF_FFFF), t_header_res'('0)),
            with_want(tx_row(12'd4095, 1'b0, 12'd4095), t_header_res'{1'b1, 1'b0,
                      32'h8000_0004, 32'h0, 1'b0, 16'h0, 1'b1, 12'd4095, 1'b0, 1'b1, 31'd0,
                      12'd4095}),
            with_want(rx_row(32'h3, 32'h6), t_header_res'{1'b1, 1'b0, 32'h0, 32'h0,
                      1'b0, 16'h0, 1'b0, 12'd0, 1'b0, 1'b0, 31'd2, 12'd0}),
            // ack with stale parity past the last send: resend, header too big
            with_want(tx_row(12'd7, 1'b0, 12'd0), t_header_res'{1'b1, 1'b0,
                      32'h8000_0005, 32'h3, 1'b0, 16'h0, 1'b1, 12'd4095, 1'b1, 1'b0, 31'd0,
                      12'd4095}),
            tx_row(12'd0, 1'b0, 12'd0),
            with_want(rx_row(32'h8000_0004, 32'h8000_0007), t_header_res'{1'b1, 1'b0,
                      32'h0, 32'h0, 1'b0, 16'h0, 1'b0, 12'd0, 1'b0, 1'b0, 31'd0, 12'd0}),
            cfg_row(CFG_IS_CLIENT, 16'd1),
            cfg_row(CFG_PORT_TAG, 16'hFFFF),
            cfg_row(CFG_MAX_PKT, 16'd4095),
            tx_row(12'd100, 1'b0, 12'd3985),
            tx_row(12'd4095, 1'b0, 12'd1),
            cfg_row(CFG_MAX_PKT, 16'd0),
            tx_row(12'd0, 1'b0, 12'd0),
            tx_row(12'd0, 1'b0, 12'd1),
            cfg_row(CFG_MAX_PKT, 16'd12),
            cfg_row(CFG_PORT_TAG, 16'h0000),
            cfg_row(CFG_IS_CLIENT, 16'd0),
            rx_row(32'h4000_0000, 32'h7FFF_FFFF),
            with_want(rx_row(32'h4000_0000, 32'h0), t_header_res'('0)),
            tx_row(12'd4095, 1'b0, 12'd4095),
            // closing rows: sticky overflow and the top sequence
            with_want(tx_row(12'd4095, 1'b1, 12'd4095), t_header_res'{1'b0, 1'b1, 32'h0,
                      32'h0, 1'b0, 16'h0, 1'b0, 12'd0, 1'b0, 1'b0, 31'd0, 12'd0}),
            tx_row(12'd0, 1'b0, 12'd0),
            rx_row(32'h7FFF_FFFF, 32'hFFFF_FFFF),
            with_want(rx_row(32'hFFFF_FFFF, 32'h0), t_header_res'{1'b0, 1'b1, 32'h0,
                      32'h0, 1'b0, 16'h0, 1'b0, 12'd0, 1'b0, 1'b0, 31'd0, 12'd0}),
            tx_row(12'd12, 1'b0, 12'd0)
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        walk_plan(0, OPEN_ROWS);

        run_phase(200, 0, 0, 1'b1, t_tag'($urandom_range(0, 65535)), 12'd4095);
        hold_seq <= hold_seq + 1;
        send_random(40);
        drain();
        send_random(160);
        run_phase(300, 88, 0, 1'b0, t_tag'($urandom_range(0, 65535)), 12'd12);
        run_phase(300, 0, 88, 1'b1, t_tag'($urandom_range(0, 65535)),
                  LEN_W'($urandom_range(0, 11)));
        run_phase(300, 29, 29, 1'($urandom_range(0, 1)), t_tag'($urandom_range(0, 65535)),
                  LEN_W'($urandom_range(12, 4095)));
        run_phase(300, 0, 0, 1'b0, t_tag'($urandom_range(0, 65535)),
                  LEN_W'(MAX_PKT_RESET));

        drain();
        stall_pct    <= 0;
        send_idle_pct = 0;
        walk_plan(OPEN_ROWS, PLAN_ROWS);
        drain();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/rcs_pkg.sv
rtl/core/rcs_cfg_regs.sv
rtl/core/rcs_seq_engine.sv
rtl/core/reliable_channel_sequencer_top.sv
sim/tb.sv
